>>> rtl/tmps_pkg.sv
// Shared types, constants and codes for the transmit mailbox priority selector.
package tmps_pkg;

   localparam int MAILBOX_DEPTH = 16;
   localparam int IDX_W         = (MAILBOX_DEPTH > 1) ? $clog2(MAILBOX_DEPTH) : 1;
   localparam int CNT_W         = $clog2(MAILBOX_DEPTH + 1);
   localparam int SLOT_W        = 4;
   localparam int CMP_W         = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int ID_W          = 29;
   localparam int PRIO_W        = 3;
   localparam int DATA_W        = 64;
   localparam int LEN_W         = 4;
   localparam int NUM_BYTES     = DATA_W / 8;

   localparam logic [LEN_W-1:0] MAX_BYTES = LEN_W'(NUM_BYTES);

   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_PUBLISH = 2'd1;
   localparam logic [1:0] OP_MARK    = 2'd2;
   localparam logic [1:0] OP_QUERY   = 2'd3;

   typedef struct packed {
      logic [1:0]        operation;
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   can_id;
      logic [PRIO_W-1:0] priority_req;
      logic [DATA_W-1:0] payload;
      logic [LEN_W-1:0]  byte_count;
   } req_payload_type;

   typedef struct packed {
      logic              add_accepted;
      logic [SLOT_W-1:0] new_slot;
      logic              op_ignored;
      logic              pending_valid;
      logic [SLOT_W-1:0] pending_slot;
      logic [ID_W-1:0]   pending_can_id;
      logic [LEN_W-1:0]  pending_length;
      logic [DATA_W-1:0] pending_payload;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic apply;
      logic scan_en;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;
   } ctrl_status_type;

endpackage

>>> rtl/tx_mailbox_priority_select.sv
// Top level of the transmit mailbox priority selector: controller, datapath, checks.
//
//   Channel   Direction  Handshake               Beat
//   req_      in         req_valid / req_ready   req_payload_type, one operation
//   rsp_      out        rsp_valid / rsp_ready   rsp_payload_type, one result
//
// An accepted beat is applied to the mailbox table in its accept cycle. The
// selector then walks every mailbox of the table one mailbox per cycle, with
// the single shared compare in the scan, and then loads the result register
// once that register is free or rsp_ready is high.
// Reset empties the table and clears every pending flag at once; no sweep runs.
// The result register decouples the sides: a new request is taken while an
// earlier result still waits, and only the final load stalls on rsp_ready.
module tx_mailbox_priority_select (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tmps_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tmps_pkg::rsp_payload_type rsp_payload
);

   tmps_pkg::ctrl_cmd_type    cmd;
   tmps_pkg::ctrl_status_type status;

   tmps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tmps_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

`ifndef ASSERT_OFF
   // After a beat is taken the block is busy scanning and takes no other.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a scan was in progress");

   // An operation cannot be both an allocated add and an ignored update.
   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.add_accepted && rsp_payload.op_ignored))
      else $error("result flags add_accepted and op_ignored both set");

   // With nothing pending the selected mailbox fields read as zero.
   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.pending_valid) |->
      (rsp_payload.pending_slot == '0 && rsp_payload.pending_length == '0 &&
       rsp_payload.pending_payload == '0 && rsp_payload.pending_can_id == '0))
      else $error("selection fields nonzero with nothing pending");

   // A stored length never exceeds the eight-byte maximum.
   a_length_saturated : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.pending_length <= tmps_pkg::MAX_BYTES))
      else $error("pending length above eight bytes");

   // The result register is loaded only at the end of a scan.
   a_load_after_scan : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !cmd.scan_en && !cmd.apply)
      else $error("result load overlaps apply or scan");
`endif

endmodule

>>> rtl/tmps_ctrl.sv
// Controller state machine: accept, scan sequencing and result register handshake.
module tmps_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  tmps_pkg::ctrl_status_type status,
   output tmps_pkg::ctrl_cmd_type    cmd
);

   tmps_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmps_pkg::ST_IDLE: begin
            if (req_valid) state_in = tmps_pkg::ST_SCAN;
         end
         tmps_pkg::ST_SCAN: begin
            if (status.scan_last) state_in = tmps_pkg::ST_LOAD;
         end
         tmps_pkg::ST_LOAD: begin
            if (!rsp_valid_ff || rsp_ready) state_in = tmps_pkg::ST_IDLE;
         end
         default: begin
            state_in = tmps_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.apply    = 1'b0;
      cmd.scan_en  = 1'b0;
      cmd.rsp_load = 1'b0;
      case (state_ff)
         tmps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.apply = req_valid;
         end
         tmps_pkg::ST_SCAN: begin
            cmd.scan_en = 1'b1;
         end
         tmps_pkg::ST_LOAD: begin
            cmd.rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/tmps_datapath.sv
// Datapath: mailbox table, one-entry-per-cycle priority scan and result register.
module tmps_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  tmps_pkg::req_payload_type req_payload,
   input  tmps_pkg::ctrl_cmd_type    cmd,
   output tmps_pkg::ctrl_status_type status,
   output tmps_pkg::rsp_payload_type rsp_payload
);

   localparam int DEPTH = tmps_pkg::MAILBOX_DEPTH;

   logic [tmps_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                        pending_ff [DEPTH];
   logic [tmps_pkg::ID_W-1:0]   ident_ff   [DEPTH];
   logic [tmps_pkg::PRIO_W-1:0] prio_ff    [DEPTH];
   logic [tmps_pkg::DATA_W-1:0] data_ff    [DEPTH];
   logic [tmps_pkg::LEN_W-1:0]  length_ff  [DEPTH];

   logic [tmps_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                        found_ff, found_in;
   logic [tmps_pkg::IDX_W-1:0]  best_idx_ff;
   logic [tmps_pkg::PRIO_W-1:0] best_prio_ff;
   logic [tmps_pkg::ID_W-1:0]   best_ident_ff;
   logic [tmps_pkg::LEN_W-1:0]  best_length_ff;
   logic [tmps_pkg::DATA_W-1:0] best_data_ff;

   logic                        accepted_ff, accepted_in;
   logic [tmps_pkg::SLOT_W-1:0] new_slot_ff, new_slot_in;
   logic                        ignored_ff, ignored_in;
   tmps_pkg::rsp_payload_type   rsp_ff, rsp_in;

   logic [1:0]                  op;
   logic                        full, slot_ok, is_add, is_upd;
   logic                        do_add, do_pub, do_mark;
   logic [tmps_pkg::IDX_W-1:0]  add_idx, slot_idx;
   logic [tmps_pkg::LEN_W-1:0]  length_in;
   logic [tmps_pkg::DATA_W-1:0] data_in;
   logic                        scan_last, take;

   assign op       = req_payload.operation;
   assign full     = (count_ff == tmps_pkg::CNT_W'(DEPTH));
   assign slot_ok  = tmps_pkg::CMP_W'(req_payload.slot) < tmps_pkg::CMP_W'(count_ff);
   assign is_add   = (op == tmps_pkg::OP_ADD);
   assign is_upd   = (op == tmps_pkg::OP_PUBLISH) || (op == tmps_pkg::OP_MARK);
   assign do_add   = cmd.apply && is_add && !full;
   assign do_pub   = cmd.apply && (op == tmps_pkg::OP_PUBLISH) && slot_ok;
   assign do_mark  = cmd.apply && (op == tmps_pkg::OP_MARK) && slot_ok;
   assign add_idx  = tmps_pkg::IDX_W'(count_ff);
   assign slot_idx = tmps_pkg::IDX_W'(req_payload.slot);
   assign count_in = do_add ? count_ff + 1'b1 : count_ff;

   assign accepted_in = is_add && !full;
   assign new_slot_in = accepted_in ? tmps_pkg::SLOT_W'(count_ff) : '0;
   assign ignored_in  = is_upd && !slot_ok;

   // Byte count saturates, and bytes at or above it are stored as zero.
   always_comb begin
      length_in = (req_payload.byte_count > tmps_pkg::MAX_BYTES) ?
                  tmps_pkg::MAX_BYTES : req_payload.byte_count;
      for (int b = 0; b < tmps_pkg::NUM_BYTES; b++) begin
         data_in[b*8 +: 8] = (tmps_pkg::LEN_W'(b) < length_in) ?
                             req_payload.payload[b*8 +: 8] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < DEPTH; i++) pending_ff[i] <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_add)  pending_ff[add_idx]  <= 1'b0;
         if (do_pub)  pending_ff[slot_idx] <= 1'b1;
         if (do_mark) pending_ff[slot_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_add) begin
         ident_ff[add_idx] <= req_payload.can_id;
         prio_ff[add_idx]  <= req_payload.priority_req;
      end
      if (do_pub) begin
         data_ff[slot_idx]   <= data_in;
         length_ff[slot_idx] <= length_in;
      end
   end

   // Scan one entry per cycle; strict less-than keeps the lowest slot on ties.
   assign scan_last = (idx_ff == tmps_pkg::IDX_W'(DEPTH - 1));
   assign take      = cmd.scan_en && pending_ff[idx_ff] &&
                      (!found_ff || (prio_ff[idx_ff] < best_prio_ff));
   assign status.scan_last = scan_last;

   always_comb begin
      idx_in   = idx_ff;
      found_in = found_ff;
      if (cmd.apply) begin
         idx_in   = '0;
         found_in = 1'b0;
      end else if (cmd.scan_en) begin
         idx_in = scan_last ? '0 : idx_ff + 1'b1;
         if (take) found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff    <= idx_ff;
         best_prio_ff   <= prio_ff[idx_ff];
         best_ident_ff  <= ident_ff[idx_ff];
         best_length_ff <= length_ff[idx_ff];
         best_data_ff   <= data_ff[idx_ff];
      end
      if (cmd.apply) begin
         accepted_ff <= accepted_in;
         new_slot_ff <= new_slot_in;
         ignored_ff  <= ignored_in;
      end
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   always_comb begin
      rsp_in.add_accepted    = accepted_ff;
      rsp_in.new_slot        = new_slot_ff;
      rsp_in.op_ignored      = ignored_ff;
      rsp_in.pending_valid   = found_ff;
      rsp_in.pending_slot    = found_ff ? tmps_pkg::SLOT_W'(best_idx_ff) : '0;
      rsp_in.pending_can_id  = found_ff ? best_ident_ff : '0;
      rsp_in.pending_length  = found_ff ? best_length_ff : '0;
      rsp_in.pending_payload = found_ff ? best_data_ff : '0;
   end

   assign rsp_payload = rsp_ff;

endmodule
